>>> rtl/core/qrs_pkg.sv
`timescale 1ns / 1ps

package qrs_pkg;

  localparam int FRAC_BITS_DEF  = 16;
  localparam int COEF_WIDTH_DEF = 32;
  localparam int ROOT_W         = 48;
  localparam int KIND_W         = 3;

  localparam logic [KIND_W-1:0] KIND_INFINITE = 3'd0;
  localparam logic [KIND_W-1:0] KIND_NONE     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_LINEAR   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DISTINCT = 3'd3;
  localparam logic [KIND_W-1:0] KIND_REPEATED = 3'd4;
  localparam logic [KIND_W-1:0] KIND_COMPLEX  = 3'd5;

endpackage

>>> rtl/core/qrs_front.sv
`timescale 1ns / 1ps

module qrs_front import qrs_pkg::*; #(
  parameter int CW = COEF_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     adv,
  input  logic                     in_v,
  input  logic signed [31:0]       coef_a,
  input  logic signed [31:0]       coef_b,
  input  logic signed [31:0]       coef_c,
  output logic                     out_v,
  output logic [2*CW+1:0]          disc,
  output logic [KIND_W-1:0]        kind,
  output logic signed [CW-1:0]     a_o,
  output logic signed [CW-1:0]     b_o,
  output logic signed [CW-1:0]     c_o
);

  localparam int PW  = 2 * CW;
  localparam int SQW = PW + 2;

  logic signed [CW-1:0] sa, sb, sc;
  logic [CW-1:0] ma, mb, mc;

  assign sa = coef_a[CW-1:0];
  assign sb = coef_b[CW-1:0];
  assign sc = coef_c[CW-1:0];
  assign ma = sa[CW-1] ? CW'(-sa) : CW'(sa);
  assign mb = sb[CW-1] ? CW'(-sb) : CW'(sb);
  assign mc = sc[CW-1] ? CW'(-sc) : CW'(sc);

  // Stage 1: the two squares/products
  logic v1;
  logic signed [CW-1:0] a1, b1, c1;
  logic [PW-1:0] b2, ac;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_v;
    end
    if (adv) begin
      a1 <= sa;
      b1 <= sb;
      c1 <= sc;
      b2 <= PW'(mb) * PW'(mb);
      ac <= PW'(ma) * PW'(mc);
    end
  end

  // Stage 2: discriminant magnitude and classification
  logic [SQW-1:0] ac4, b2x, d_next;
  logic ac_neg, dneg;
  logic [KIND_W-1:0] kind_next;

  always_comb begin
    ac4 = {ac, 2'b00};
    b2x = SQW'(b2);
    ac_neg = (a1[CW-1] ^ c1[CW-1]) && (ac != '0);
    dneg = 1'b0;
    if (ac_neg) begin
      d_next = b2x + ac4;
    end else if (ac4 <= b2x) begin
      d_next = b2x - ac4;
    end else begin
      d_next = ac4 - b2x;
      dneg = 1'b1;
    end
    if (a1 == '0) begin
      if (b1 == '0) begin
        kind_next = (c1 == '0) ? KIND_INFINITE : KIND_NONE;
      end else begin
        kind_next = KIND_LINEAR;
      end
    end else if (d_next == '0) begin
      kind_next = KIND_REPEATED;
    end else if (dneg) begin
      kind_next = KIND_COMPLEX;
    end else begin
      kind_next = KIND_DISTINCT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (adv) begin
      out_v <= v1;
    end
    if (adv) begin
      disc <= d_next;
      kind <= kind_next;
      a_o  <= a1;
      b_o  <= b1;
      c_o  <= c1;
    end
  end

endmodule

>>> rtl/core/qrs_sqrt.sv
`timescale 1ns / 1ps

module qrs_sqrt #(
  parameter int SW   = 33,
  parameter int CTXW = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              in_v,
  input  logic [2*SW-1:0]   rad_in,
  input  logic [CTXW-1:0]   ctx_in,
  output logic              out_v,
  output logic [SW-1:0]     root,
  output logic [CTXW-1:0]   ctx_out
);

  localparam int RW = 2 * SW;

  logic            v   [SW+1];
  logic [RW-1:0]   rad [SW+1];
  logic [SW+1:0]   rem [SW+1];
  logic [SW-1:0]   rt  [SW+1];
  logic [CTXW-1:0] ctx [SW+1];

  always_comb begin
    v[0]   = in_v;
    rad[0] = rad_in;
    rem[0] = '0;
    rt[0]  = '0;
    ctx[0] = ctx_in;
  end

  // One root bit per stage, most significant first
  for (genvar k = 1; k <= SW; k++) begin : g_stage
    logic [SW+2:0] cat, trial;
    logic ge;

    always_comb begin
      cat   = {rem[k-1][SW:0], rad[k-1][RW-1:RW-2]};
      trial = (SW+3)'({rt[k-1], 2'b01});
      ge    = cat >= trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (adv) begin
        v[k] <= v[k-1];
      end
      if (adv) begin
        rad[k] <= {rad[k-1][RW-3:0], 2'b00};
        rem[k] <= ge ? (SW+2)'(cat - trial) : (SW+2)'(cat);
        rt[k]  <= {rt[k-1][SW-2:0], ge};
        ctx[k] <= ctx[k-1];
      end
    end
  end

  assign out_v   = v[SW];
  assign root    = rt[SW];
  assign ctx_out = ctx[SW];

endmodule

>>> rtl/core/qrs_div.sv
`timescale 1ns / 1ps

module qrs_div #(
  parameter int NMW  = 34,
  parameter int DW   = 33,
  parameter int FB   = 16,
  parameter int CTXW = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 adv,
  input  logic                 in_v,
  input  logic [NMW-1:0]       num,
  input  logic [DW-1:0]        den,
  input  logic [CTXW-1:0]      ctx_in,
  output logic                 out_v,
  output logic [NMW+FB-1:0]    quo,
  output logic [CTXW-1:0]      ctx_out
);

  localparam int QW = NMW + FB;

  logic            v   [QW+1];
  logic [QW-1:0]   nm  [QW+1];
  logic [QW-1:0]   q   [QW+1];
  logic [DW-1:0]   rem [QW+1];
  logic [DW-1:0]   dv  [QW+1];
  logic [CTXW-1:0] ctx [QW+1];

  always_comb begin
    v[0]   = in_v;
    nm[0]  = {num, FB'(0)};
    q[0]   = '0;
    rem[0] = '0;
    dv[0]  = den;
    ctx[0] = ctx_in;
  end

  // Restoring division, one quotient bit per stage
  for (genvar k = 1; k <= QW; k++) begin : g_stage
    logic [DW:0] trial;
    logic ge;

    always_comb begin
      trial = {rem[k-1], nm[k-1][QW-1]};
      ge    = trial >= {1'b0, dv[k-1]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (adv) begin
        v[k] <= v[k-1];
      end
      if (adv) begin
        nm[k]  <= nm[k-1] << 1;
        q[k]   <= {q[k-1][QW-2:0], ge};
        rem[k] <= ge ? DW'(trial - {1'b0, dv[k-1]}) : DW'(trial);
        dv[k]  <= dv[k-1];
        ctx[k] <= ctx[k-1];
      end
    end
  end

  assign out_v   = v[QW];
  assign quo     = q[QW];
  assign ctx_out = ctx[QW];

endmodule

>>> rtl/core/quadratic_root_solver.sv
`timescale 1ns / 1ps

// Solves a*x^2 + b*x + c = 0 for signed fixed-point coefficients (FRAC_BITS fraction
// bits, low COEF_WIDTH bits of each port used) and returns a kind code with two
// Q32.16-style roots that saturate and raise overflow. Fully pipelined: one coefficient
// set per cycle unless out_stall holds the pipeline. Stages: the front end, the
// bit-per-stage square root, the numerator register, the two bit-per-stage dividers
// and the output register. in_stall rises only while a finished result waits on
// out_stall; then the whole pipeline holds.
module quadratic_root_solver import qrs_pkg::*; #(
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int COEF_WIDTH = COEF_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [31:0]       coef_a,
  input  logic signed [31:0]       coef_b,
  input  logic signed [31:0]       coef_c,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [KIND_W-1:0]        root_kind,
  output logic signed [ROOT_W-1:0] root_one,
  output logic signed [ROOT_W-1:0] root_two,
  output logic                     overflow
);

  localparam int CW   = COEF_WIDTH;
  localparam int SW   = CW + 1;
  localparam int NW   = CW + 3;
  localparam int NMW  = CW + 2;
  localparam int DW   = CW + 1;
  localparam int QW   = NMW + FRAC_BITS;
  localparam int QX   = ((QW > ROOT_W) ? QW : ROOT_W) + 1;
  localparam int CTXW = KIND_W + 3 * CW;

  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Front end: products and discriminant
  logic fv;
  logic [2*SW-1:0] disc;
  logic [KIND_W-1:0] fkind;
  logic signed [CW-1:0] fa, fb, fc;

  qrs_front #(.CW(CW)) u_front (
    .clk(clk), .rst(rst), .adv(adv), .in_v(in_valid && !in_stall),
    .coef_a(coef_a), .coef_b(coef_b), .coef_c(coef_c),
    .out_v(fv), .disc(disc), .kind(fkind), .a_o(fa), .b_o(fb), .c_o(fc)
  );

  logic sv;
  logic [SW-1:0] s;
  logic [CTXW-1:0] sctx;

  qrs_sqrt #(.SW(SW), .CTXW(CTXW)) u_sqrt (
    .clk(clk), .rst(rst), .adv(adv), .in_v(fv), .rad_in(disc),
    .ctx_in({fkind, fa, fb, fc}),
    .out_v(sv), .root(s), .ctx_out(sctx)
  );

  // Numerator/denominator selection
  logic [KIND_W-1:0] skind;
  logic signed [CW-1:0] sa, sb, sc;
  logic signed [NW-1:0] nb, ns, n1, n2;
  logic signed [DW:0] den;
  logic [NMW-1:0] m1_next, m2_next;
  logic [DW-1:0] dm_next;

  always_comb begin
    {skind, sa, sb, sc} = sctx;
    nb  = -NW'(sb);
    ns  = NW'({2'b00, s});
    den = (DW+1)'(sa) <<< 1;
    n1  = nb;
    n2  = '0;
    case (skind)
      KIND_LINEAR: begin
        n1  = -NW'(sc);
        den = (DW+1)'(sb);
      end
      KIND_DISTINCT: begin
        n1 = nb + ns;
        n2 = nb - ns;
      end
      KIND_COMPLEX: begin
        n2 = ns;
      end
      default: begin
        n1 = nb;
      end
    endcase
    m1_next = n1[NW-1] ? NMW'(-n1) : NMW'(n1);
    m2_next = n2[NW-1] ? NMW'(-n2) : NMW'(n2);
    dm_next = den[DW] ? DW'(-den) : DW'(den);
  end

  logic nv;
  logic [NMW-1:0] m1, m2;
  logic [DW-1:0] dm;
  logic ng1, ng2;
  logic [KIND_W-1:0] nkind;

  always_ff @(posedge clk) begin
    if (rst) begin
      nv <= 1'b0;
    end else if (adv) begin
      nv <= sv;
    end
    if (adv) begin
      m1    <= m1_next;
      m2    <= m2_next;
      dm    <= dm_next;
      ng1   <= n1[NW-1] ^ den[DW];
      ng2   <= n2[NW-1] ^ den[DW];
      nkind <= skind;
    end
  end

  logic dv1, dv2;
  logic [QW-1:0] q1, q2;
  logic [KIND_W:0] dctx1;
  logic dng2;

  qrs_div #(.NMW(NMW), .DW(DW), .FB(FRAC_BITS), .CTXW(KIND_W+1)) u_div_one (
    .clk(clk), .rst(rst), .adv(adv), .in_v(nv), .num(m1), .den(dm),
    .ctx_in({nkind, ng1}), .out_v(dv1), .quo(q1), .ctx_out(dctx1)
  );

  qrs_div #(.NMW(NMW), .DW(DW), .FB(FRAC_BITS), .CTXW(1)) u_div_two (
    .clk(clk), .rst(rst), .adv(adv), .in_v(nv), .num(m2), .den(dm),
    .ctx_in(ng2), .out_v(dv2), .quo(q2), .ctx_out(dng2)
  );

  function automatic logic [ROOT_W:0] sat(input logic [QW-1:0] q, input logic neg);
    logic [QX-1:0] qx, lim, qv;
    logic ov;
    qx  = QX'(q);
    lim = QX'(1) << (ROOT_W - 1);
    ov  = 1'b0;
    if (neg) begin
      qv = qx;
      if (qx > lim) begin
        qv = lim;
        ov = 1'b1;
      end
      qv = -qv;
    end else begin
      qv = qx;
      if (qx > lim - QX'(1)) begin
        qv = lim - QX'(1);
        ov = 1'b1;
      end
    end
    return {ov, qv[ROOT_W-1:0]};
  endfunction

  // Output register: saturate, zero unused roots
  logic [KIND_W-1:0] dkind;
  logic [ROOT_W:0] r1s, r2s;
  logic use1, use2;

  always_comb begin
    dkind = dctx1[KIND_W:1];
    r1s   = sat(q1, dctx1[0]);
    r2s   = sat(q2, dng2);
    use1  = (dkind != KIND_INFINITE) && (dkind != KIND_NONE);
    use2  = (dkind == KIND_DISTINCT) || (dkind == KIND_COMPLEX);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv1 && dv2;
    end
    if (adv) begin
      root_kind <= dkind;
      root_one  <= use1 ? r1s[ROOT_W-1:0] : '0;
      root_two  <= use2 ? r2s[ROOT_W-1:0] : '0;
      overflow  <= (use1 && r1s[ROOT_W]) || (use2 && r2s[ROOT_W]);
    end
  end

endmodule
